// ----- rtl/core/pesr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pesr_pkg: shared constants of the polyline equal spacing resampler
// Field widths, register indexes and reset values imported by all modules.
// ----------------------------------------------------------------------------
package pesr_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int LOC_BITS       = 19;
	localparam int CFG_W          = 8;
	localparam int CFG_IDX_W      = 1;
	localparam int MAX_PTS        = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SPACING   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'b1;

	localparam logic [CFG_W-1:0] SPACING_RST   = 8'd24;
	localparam logic [CFG_W-1:0] STEP_SIZE_RST = 8'd26;

endpackage
`default_nettype wire

// ----- rtl/core/polyline_equal_spacing_resampler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_equal_spacing_resampler: equal spacing point placement on strokes
// Vertices enter on the in channel (kind, x, y); points leave on the out
// channel (loc_x, loc_y, last), last marking the final point of a vertex.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low. spacing and step_size are written through cfg_wr_en,
// cfg_index and cfg_data, only while the block is idle; the user must keep
// to this, as the block does not enforce it. A stroke-opening vertex is
// emitted as a single point with last set. A segment vertex is set up by a
// multiply and the bit-serial slope divider, then each search step and each
// distance check runs difference, square and compare; up to 64 points are
// placed per vertex.
// A two-entry command queue lets the next vertex be set up while points of
// the previous one are searched. When the receiver stalls, the output
// register holds its point and the search waits for the slot.
// Reset clears the stroke state, empties the queue and restores
// spacing 24 and step_size 26.
// ----------------------------------------------------------------------------
module polyline_equal_spacing_resampler import pesr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  kind,
	input  wire logic [COORD_BITS-1:0] x,
	input  wire logic [COORD_BITS-1:0] y,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [LOC_BITS-1:0] loc_x,
	output logic signed [LOC_BITS-1:0] loc_y,
	output logic                       last,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam int SX_W = CFG_W + 1;
	localparam int SY_W = COORD_BITS + CFG_W + 1;

	typedef struct packed {
		logic                   is_start;
		logic [COORD_BITS-1:0]  vx;
		logic [COORD_BITS-1:0]  vy;
		logic [COORD_BITS-1:0]  px;
		logic [COORD_BITS-1:0]  py;
		logic signed [SX_W-1:0] sx;
		logic signed [SY_W-1:0] sy;
	} cmd_t;

	logic [CFG_W-1:0] spacing_q, step_size_q;
	cmd_t             wr_cmd, rd_cmd;
	logic             push, full, pop, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q   <= SPACING_RST;
			step_size_q <= STEP_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SPACING:   spacing_q   <= cfg_data;
				REG_STEP_SIZE: step_size_q <= cfg_data;
				default:       spacing_q   <= spacing_q;
			endcase
		end
	end

	pesr_front #(
		.COORD_BITS(COORD_BITS),
		.cmd_t     (cmd_t)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.x        (x),
		.y        (y),
		.step_size(step_size_q),
		.push     (push),
		.full     (full),
		.cmd      (wr_cmd)
	);

	pesr_fifo #(
		.cmd_t(cmd_t)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_cmd),
		.full   (full),
		.pop    (pop),
		.rd_data(rd_cmd),
		.empty  (empty)
	);

	pesr_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.cmd_t     (cmd_t)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!empty),
		.cmd      (rd_cmd),
		.pop      (pop),
		.spacing  (spacing_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.loc_x    (loc_x),
		.loc_y    (loc_y),
		.last     (last)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |=> push)
		else $error("command push lost while queue full");
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command pop from empty queue");
	a_stall_until_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_stall)
		else $error("vertex accepted while command pending");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/pesr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pesr_front: vertex intake and segment setup
// Accepts vertices, tracks the stroke, and builds one command per vertex
// with the per-step position increments (slope divided bit-serially).
// ----------------------------------------------------------------------------
module pesr_front import pesr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter type cmd_t = logic
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  kind,
	input  wire logic [COORD_BITS-1:0] x,
	input  wire logic [COORD_BITS-1:0] y,
	input  wire logic [CFG_W-1:0]      step_size,
	output logic                       push,
	input  wire logic                  full,
	output cmd_t                       cmd
);

	localparam int NUM_W = COORD_BITS + CFG_W;
	localparam int SX_W  = CFG_W + 1;
	localparam int SY_W  = NUM_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t                 state_q;
	logic                    open_q;
	logic [COORD_BITS-1:0]   pvx_q, pvy_q;
	cmd_t                    cmd_q;
	logic [COORD_BITS-1:0]   adx_q, ady_q;
	logic                    dxneg_q, dyneg_q;
	logic [NUM_W-1:0]        num_q, quo_q;
	logic [COORD_BITS-1:0]   rem_q;
	logic [CNT_W-1:0]        cnt_q;

	logic signed [COORD_BITS:0] dxp, dyp;
	logic [COORD_BITS:0]        rem_sh;
	logic                       qbit;
	logic [NUM_W-1:0]           quo_nxt;
	logic signed [SX_W-1:0]     st_s;
	logic signed [SY_W-1:0]     q_s;

	assign dxp     = signed'({1'b0, x}) - signed'({1'b0, pvx_q});
	assign dyp     = signed'({1'b0, y}) - signed'({1'b0, pvy_q});
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign qbit    = rem_sh >= {1'b0, adx_q};
	assign quo_nxt = {quo_q[NUM_W-2:0], qbit};
	assign st_s    = signed'({1'b0, step_size});
	assign q_s     = signed'({1'b0, quo_nxt});

	assign in_stall = state_q != F_IDLE;
	assign push     = state_q == F_PUSH;
	assign cmd      = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			open_q  <= 1'b0;
			pvx_q   <= '0;
			pvy_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						open_q    <= 1'b1;
						pvx_q     <= x;
						pvy_q     <= y;
						cmd_q.vx  <= x;
						cmd_q.vy  <= y;
						cmd_q.px  <= pvx_q;
						cmd_q.py  <= pvy_q;
						adx_q     <= dxp[COORD_BITS] ? COORD_BITS'(-dxp) : dxp[COORD_BITS-1:0];
						ady_q     <= dyp[COORD_BITS] ? COORD_BITS'(-dyp) : dyp[COORD_BITS-1:0];
						dxneg_q   <= dxp[COORD_BITS];
						dyneg_q   <= dyp[COORD_BITS];
						cmd_q.sx  <= '0;
						cmd_q.sy  <= '0;
						if (!kind || !open_q) begin
							cmd_q.is_start <= 1'b1;
							state_q        <= F_PUSH;
						end else begin
							cmd_q.is_start <= 1'b0;
							state_q        <= F_MUL;
						end
					end
				end
				F_MUL: begin
					num_q <= ady_q * step_size;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					if (adx_q == '0) begin
						if (ady_q == '0) cmd_q.sy <= '0;
						else cmd_q.sy <= dyneg_q ? -SY_W'(st_s) : SY_W'(st_s);
						state_q <= F_PUSH;
					end else begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= qbit ? COORD_BITS'(rem_sh - {1'b0, adx_q}) : rem_sh[COORD_BITS-1:0];
					num_q <= num_q << 1;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						cmd_q.sx <= dxneg_q ? -st_s : st_s;
						cmd_q.sy <= dyneg_q ? -q_s : q_s;
						state_q  <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pesr_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pesr_fifo: two-entry command queue
// Decouples segment setup from the point search.
// ----------------------------------------------------------------------------
module pesr_fifo import pesr_pkg::*; #(
	parameter type cmd_t = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wr_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pesr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pesr_back: point search and output
// Steps along each segment, compares squared distances to the spacing and
// emits points through an output register.
// ----------------------------------------------------------------------------
module pesr_back import pesr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter type cmd_t = logic
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	input  cmd_t                            cmd,
	output logic                            pop,
	input  wire logic [CFG_W-1:0]           spacing,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [LOC_BITS-1:0]      loc_x,
	output logic signed [LOC_BITS-1:0]      loc_y,
	output logic                            last
);

	localparam int LIM_W = CFG_W + FRAC_BITS;
	localparam int CAP_W = LIM_W + 2;
	localparam int POS_W = LOC_BITS + COORD_BITS + FRAC_BITS;
	localparam int DIF_W = POS_W + 1;
	localparam int SQ_W  = 2 * LIM_W;
	localparam int N_W   = $clog2(MAX_PTS + 1);
	localparam logic signed [POS_W-1:0] LOC_HI = POS_W'(2 ** (LOC_BITS - 1) - 1);
	localparam logic signed [POS_W-1:0] LOC_LO = -LOC_HI - POS_W'(1);

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_DIFF   = 5'b00010,
		B_SQR    = 5'b00100,
		B_DECIDE = 5'b01000,
		B_EMIT   = 5'b10000
	} bstate_t;

	function automatic logic signed [LOC_BITS-1:0] sat_loc(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] r;
		begin
			r = v;
			if (v > LOC_HI) r = LOC_HI;
			if (v < LOC_LO) r = LOC_LO;
			return r[LOC_BITS-1:0];
		end
	endfunction

	function automatic logic signed [POS_W-1:0] to_pos(input logic [COORD_BITS-1:0] v);
		return signed'({{LOC_BITS{1'b0}}, v, {FRAC_BITS{1'b0}}});
	endfunction

	bstate_t                     state_q;
	logic                        outer_q, emit_last_q;
	logic [N_W-1:0]              n_q;
	logic [CAP_W-1:0]            steps_q, cap_q;
	logic [SQ_W-1:0]             limsq_q;
	logic signed [POS_W-1:0]     ex_q, ey_q, cx_q, cy_q;
	logic signed [$bits(cmd.sx)-1:0] sx_q;
	logic signed [$bits(cmd.sy)-1:0] sy_q;
	logic signed [LOC_BITS-1:0]  lx_q, ly_q;
	logic [LIM_W-1:0]            ax_s1, ay_s1;
	logic                        big_s1, big_s2;
	logic [SQ_W-1:0]             sqx_s2, sqy_s2;
	logic                        out_valid_q, last_q;
	logic signed [LOC_BITS-1:0]  loc_x_q, loc_y_q;

	logic [LIM_W-1:0]            lim;
	logic signed [DIF_W-1:0]     dax, day;
	logic [DIF_W-1:0]            ax, ay;
	logic                        far;
	logic signed [LOC_BITS-1:0]  cxs, cys;
	logic                        slot;

	assign lim = {spacing, {FRAC_BITS{1'b0}}};
	assign dax = outer_q ? DIF_W'(ex_q) - DIF_W'(lx_q) : DIF_W'(lx_q) - DIF_W'(cx_q);
	assign day = outer_q ? DIF_W'(ey_q) - DIF_W'(ly_q) : DIF_W'(ly_q) - DIF_W'(cy_q);
	assign ax  = dax[DIF_W-1] ? DIF_W'(-dax) : DIF_W'(dax);
	assign ay  = day[DIF_W-1] ? DIF_W'(-day) : DIF_W'(day);
	assign far = big_s2 || ({1'b0, sqx_s2} + {1'b0, sqy_s2} >= {1'b0, limsq_q});
	assign cxs = sat_loc(cx_q);
	assign cys = sat_loc(cy_q);
	assign slot = !out_valid_q || !out_stall;

	assign pop       = state_q == B_IDLE && cmd_valid;
	assign out_valid = out_valid_q;
	assign loc_x     = loc_x_q;
	assign loc_y     = loc_y_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		ax_s1  <= ax[LIM_W-1:0];
		ay_s1  <= ay[LIM_W-1:0];
		big_s1 <= (ax >= DIF_W'(lim)) || (ay >= DIF_W'(lim));
		sqx_s2 <= ax_s1 * ax_s1;
		sqy_s2 <= ay_s1 * ay_s1;
		big_s2 <= big_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			outer_q     <= 1'b0;
			emit_last_q <= 1'b0;
			n_q         <= '0;
			steps_q     <= '0;
			lx_q        <= '0;
			ly_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EMIT && slot) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						ex_q    <= to_pos(cmd.vx);
						ey_q    <= to_pos(cmd.vy);
						cx_q    <= to_pos(cmd.px);
						cy_q    <= to_pos(cmd.py);
						sx_q    <= cmd.sx;
						sy_q    <= cmd.sy;
						limsq_q <= lim * lim;
						cap_q   <= CAP_W'({lim, 1'b0}) + CAP_W'(2);
						n_q     <= '0;
						if (cmd.is_start) begin
							lx_q        <= sat_loc(to_pos(cmd.vx));
							ly_q        <= sat_loc(to_pos(cmd.vy));
							emit_last_q <= 1'b1;
							state_q     <= B_EMIT;
						end else begin
							outer_q <= 1'b1;
							state_q <= B_DIFF;
						end
					end
				end
				B_DIFF:   state_q <= B_SQR;
				B_SQR:    state_q <= B_DECIDE;
				B_DECIDE: begin
					if (outer_q) begin
						if (far) begin
							if (n_q != '0) begin
								emit_last_q <= 1'b0;
								state_q     <= B_EMIT;
							end else begin
								outer_q <= 1'b0;
								steps_q <= '0;
								state_q <= B_DIFF;
							end
						end else if (n_q != '0) begin
							emit_last_q <= 1'b1;
							state_q     <= B_EMIT;
						end else begin
							state_q <= B_IDLE;
						end
					end else if (!far && steps_q < cap_q) begin
						cx_q    <= cx_q + POS_W'(sx_q);
						cy_q    <= cy_q + POS_W'(sy_q);
						steps_q <= steps_q + 1'b1;
						state_q <= B_DIFF;
					end else begin
						cx_q <= POS_W'(cxs);
						cy_q <= POS_W'(cys);
						lx_q <= cxs;
						ly_q <= cys;
						n_q  <= n_q + 1'b1;
						if (n_q == N_W'(MAX_PTS - 1)) begin
							emit_last_q <= 1'b1;
							state_q     <= B_EMIT;
						end else begin
							outer_q <= 1'b1;
							state_q <= B_DIFF;
						end
					end
				end
				B_EMIT: begin
					if (slot) begin
						loc_x_q     <= lx_q;
						loc_y_q     <= ly_q;
						last_q      <= emit_last_q;
						outer_q     <= 1'b0;
						steps_q     <= '0;
						state_q     <= emit_last_q ? B_IDLE : B_DIFF;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
